>>> design/aapr_pkg.sv
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared types, widths and register codes of the axis-angle path rotator.
// ----------------------------------------------------------------------------
package aapr_pkg;

   localparam int VEC_W     = 32;  // Q16.16 vector component
   localparam int COEF_W    = 18;  // Q1.16 axis, cosine and sine
   localparam int FRAC      = 16;  // fraction bits dropped by every shift
   localparam int PROD_W    = VEC_W + COEF_W;        // k_i * v_j, c * v_i
   localparam int DIFF_W    = PROD_W + 1;            // cross product before shift
   localparam int CROSS_W   = DIFF_W - FRAC;         // cross product after shift
   localparam int DSUM_W    = PROD_W + 2;            // dot product before shift
   localparam int DOT_W     = DSUM_W - FRAC;         // dot product after shift
   localparam int OMC_W     = COEF_W + 1;            // one minus cosine
   localparam int WPROD_W   = DOT_W + OMC_W;         // dot * (1 - c)
   localparam int W_W       = WPROD_W - FRAC;        // scale of the axis term
   localparam int SC_W      = CROSS_W + COEF_W;      // s * cross
   localparam int WK_W      = W_W + COEF_W;          // w * k_i
   localparam int SUM_W     = WK_W + 1;              // full-precision output sum
   localparam int RES_W     = SUM_W - FRAC;          // shifted, before saturation
   localparam int ONE_Q16   = 65536;
   localparam int LANE_STAGES = 5;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIN    = 3'd4;

   typedef struct packed {
      logic signed [VEC_W-1:0] point_x;
      logic signed [VEC_W-1:0] point_y;
      logic signed [VEC_W-1:0] point_z;
      logic signed [VEC_W-1:0] tangent_x;
      logic signed [VEC_W-1:0] tangent_y;
      logic signed [VEC_W-1:0] tangent_z;
      logic                    end_of_path;
   } req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] rot_point_x;
      logic signed [VEC_W-1:0] rot_point_y;
      logic signed [VEC_W-1:0] rot_point_z;
      logic signed [VEC_W-1:0] rot_tangent_x;
      logic signed [VEC_W-1:0] rot_tangent_y;
      logic signed [VEC_W-1:0] rot_tangent_z;
      logic                    last_element;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] axis_x;
      logic signed [COEF_W-1:0] axis_y;
      logic signed [COEF_W-1:0] axis_z;
      logic signed [COEF_W-1:0] cos_angle;
      logic signed [COEF_W-1:0] sin_angle;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctrl_type;

endpackage

>>> design/aapr_lane.sv
// ----------------------------------------------------------------------------
// aapr_lane
// Five-stage pipeline that rotates one 3D vector by Rodrigues' formula.
// ----------------------------------------------------------------------------
module aapr_lane (
   input  logic                              clock,
   input  aapr_pkg::cfg_type                 cfg,
   input  logic signed [aapr_pkg::VEC_W-1:0] vec [3],
   output logic signed [aapr_pkg::RES_W-1:0] res [3]
);
   import aapr_pkg::*;

   logic signed [COEF_W-1:0]  k [3];
   logic signed [OMC_W-1:0]   omc;

   logic signed [PROD_W-1:0]  kv_in [3][3];
   logic signed [PROD_W-1:0]  kv_ff [3][3];
   logic signed [PROD_W-1:0]  cv_in [3];
   logic signed [PROD_W-1:0]  cv_s1_ff [3];
   logic signed [PROD_W-1:0]  cv_s2_ff [3];
   logic signed [PROD_W-1:0]  cv_s3_ff [3];

   logic signed [DIFF_W-1:0]  diff [3];
   logic signed [DSUM_W-1:0]  dsum;
   logic signed [CROSS_W-1:0] cross_in [3];
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [DOT_W-1:0]   dot_in;
   logic signed [DOT_W-1:0]   dot_ff;

   logic signed [WPROD_W-1:0] wprod_in;
   logic signed [WPROD_W-1:0] wprod_ff;
   logic signed [SC_W-1:0]    sc_in [3];
   logic signed [SC_W-1:0]    sc_ff [3];

   logic signed [W_W-1:0]     w;
   logic signed [WK_W-1:0]    wk_in [3];
   logic signed [WK_W-1:0]    wk_ff [3];
   logic signed [SUM_W-1:0]   part_in [3];
   logic signed [SUM_W-1:0]   part_ff [3];

   logic signed [SUM_W-1:0]   total [3];
   logic signed [RES_W-1:0]   res_in [3];
   logic signed [RES_W-1:0]   res_ff [3];

   assign k[0] = cfg.axis_x;
   assign k[1] = cfg.axis_y;
   assign k[2] = cfg.axis_z;
   assign omc  = OMC_W'(ONE_Q16) - OMC_W'(cfg.cos_angle);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            kv_in[i][j] = PROD_W'(k[i]) * PROD_W'(vec[j]);
         end
         cv_in[i] = PROD_W'(cfg.cos_angle) * PROD_W'(vec[i]);
      end

      diff[0] = DIFF_W'(kv_ff[1][2]) - DIFF_W'(kv_ff[2][1]);
      diff[1] = DIFF_W'(kv_ff[2][0]) - DIFF_W'(kv_ff[0][2]);
      diff[2] = DIFF_W'(kv_ff[0][1]) - DIFF_W'(kv_ff[1][0]);
      dsum    = DSUM_W'(kv_ff[0][0]) + DSUM_W'(kv_ff[1][1]) + DSUM_W'(kv_ff[2][2]);
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = CROSS_W'(diff[i] >>> FRAC);
      end
      dot_in = DOT_W'(dsum >>> FRAC);

      wprod_in = WPROD_W'(dot_ff) * WPROD_W'(omc);
      for (int i = 0; i < 3; i++) begin
         sc_in[i] = SC_W'(cfg.sin_angle) * SC_W'(cross_ff[i]);
      end

      w = W_W'(wprod_ff >>> FRAC);
      for (int i = 0; i < 3; i++) begin
         wk_in[i]   = WK_W'(w) * WK_W'(k[i]);
         part_in[i] = SUM_W'(cv_s3_ff[i]) + SUM_W'(sc_ff[i]);
         total[i]   = part_ff[i] + SUM_W'(wk_ff[i]);
         res_in[i]  = RES_W'(total[i] >>> FRAC);
      end
   end

   always_ff @(posedge clock) begin
      kv_ff    <= kv_in;
      cv_s1_ff <= cv_in;
      cross_ff <= cross_in;
      dot_ff   <= dot_in;
      cv_s2_ff <= cv_s1_ff;
      wprod_ff <= wprod_in;
      sc_ff    <= sc_in;
      cv_s3_ff <= cv_s2_ff;
      wk_ff    <= wk_in;
      part_ff  <= part_in;
      res_ff   <= res_in;
   end

   assign res = res_ff;

endmodule

>>> design/aapr_merge.sv
// ----------------------------------------------------------------------------
// aapr_merge
// Saturates the lane results and packs them into the result transaction.
// ----------------------------------------------------------------------------
module aapr_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  aapr_pkg::ctrl_type                ctrl,
   input  logic signed [aapr_pkg::RES_W-1:0] point_res [3],
   input  logic signed [aapr_pkg::RES_W-1:0] tangent_res [3],
   output logic                              rsp_valid,
   output aapr_pkg::rsp_type                 rsp_data
);
   import aapr_pkg::*;

   localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
   localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

   function automatic logic signed [VEC_W-1:0] sat(input logic signed [RES_W-1:0] x);
      logic [RES_W-VEC_W:0] head;
      head = x[RES_W-1:VEC_W-1];
      if (head == '0 || head == '1) begin
         return x[VEC_W-1:0];
      end else if (x[RES_W-1]) begin
         return VEC_MIN;
      end else begin
         return VEC_MAX;
      end
   endfunction

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in                   = ctrl.valid;
      data_in.rot_point_x        = sat(point_res[0]);
      data_in.rot_point_y        = sat(point_res[1]);
      data_in.rot_point_z        = sat(point_res[2]);
      data_in.rot_tangent_x      = sat(tangent_res[0]);
      data_in.rot_tangent_y      = sat(tangent_res[1]);
      data_in.rot_tangent_z      = sat(tangent_res[2]);
      data_in.last_element       = ctrl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> design/axis_angle_path_rotator_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_path_rotator_unit
// Each result is registered in the merge stage and shown for a single cycle.
// Throughput: one transaction per cycle outside reset, set by each lane's pipeline.
// Reset: synchronous; busy is high during reset, the pipeline empties and the
// registers return to the identity rotation about z. The receiver cannot stall.
// ----------------------------------------------------------------------------
module axis_angle_path_rotator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  aapr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output aapr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [aapr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aapr_pkg::COEF_W-1:0]           csr_write_data
);
   import aapr_pkg::*;

   // Configuration registers, read by the lanes at every stage. Software must load
   // them only while no transaction is in flight; the block does not enforce it.
   cfg_type cfg_ff, cfg_in;

   // Valid and end-of-path mark travel alongside the lane pipelines.
   ctrl_type ctrl_ff [LANE_STAGES];
   ctrl_type ctrl_in;

   logic signed [VEC_W-1:0] point_vec   [3];
   logic signed [VEC_W-1:0] tangent_vec [3];
   logic signed [RES_W-1:0] point_res   [3];
   logic signed [RES_W-1:0] tangent_res [3];

   // The block never holds off a request except while reset is applied.
   assign busy = reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_AXIS_X: cfg_in.axis_x    = csr_write_data;
            REG_AXIS_Y: cfg_in.axis_y    = csr_write_data;
            REG_AXIS_Z: cfg_in.axis_z    = csr_write_data;
            REG_COS:    cfg_in.cos_angle = csr_write_data;
            REG_SIN:    cfg_in.sin_angle = csr_write_data;
            default:    cfg_in = cfg_ff;  // Unmapped indexes are ignored.
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_x    <= '0;
         cfg_ff.axis_y    <= '0;
         cfg_ff.axis_z    <= COEF_W'(ONE_Q16);
         cfg_ff.cos_angle <= COEF_W'(ONE_Q16);
         cfg_ff.sin_angle <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign ctrl_in.valid = start && !busy;
   assign ctrl_in.last  = req_data.end_of_path;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_STAGES; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else begin
         ctrl_ff[0] <= ctrl_in;
         for (int i = 1; i < LANE_STAGES; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   assign point_vec[0]   = req_data.point_x;
   assign point_vec[1]   = req_data.point_y;
   assign point_vec[2]   = req_data.point_z;
   assign tangent_vec[0] = req_data.tangent_x;
   assign tangent_vec[1] = req_data.tangent_y;
   assign tangent_vec[2] = req_data.tangent_z;

   // The point and the tangent are rotated by two identical lanes side by side.
   aapr_lane u_point_lane (
      .clock (clock),
      .cfg   (cfg_ff),
      .vec   (point_vec),
      .res   (point_res)
   );

   aapr_lane u_tangent_lane (
      .clock (clock),
      .cfg   (cfg_ff),
      .vec   (tangent_vec),
      .res   (tangent_res)
   );

   // The merge stage saturates both lanes and forms the result transaction.
   aapr_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl_ff[LANE_STAGES-1]),
      .point_res   (point_res),
      .tangent_res (tangent_res),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

>>> design/aapr_checker.sv
// ----------------------------------------------------------------------------
// aapr_checker
// Port-level checks of the rotator's timing, bound to the top level.
// ----------------------------------------------------------------------------
module aapr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input aapr_pkg::req_type req_data,
   input logic              rsp_valid,
   input aapr_pkg::rsp_type rsp_data
);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_busy_only_in_reset: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy outside reset");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6
         (rsp_valid && rsp_data.last_element == $past(req_data.end_of_path, 6)))
      else $error("missing result or wrong end-of-path mark");

   a_no_spurious: assert property (@(posedge clock)
      !(start && !busy) |-> ##6 !rsp_valid)
      else $error("result without a request");

endmodule

bind axis_angle_path_rotator_unit aapr_checker u_checker (.*);

>>> verif/tb_axis_angle_path_rotator_unit.sv
// ----------------------------------------------------------------------------
// tb_axis_angle_path_rotator_unit
// Self-checking testbench of the axis-angle path rotator. Each accepted path
// element is rotated by a bit-exact predictor and the expected result is
// queued. Every result strobe is checked field by field against the oldest
// queued result. Directed tests cover the identity rotation, quarter turns,
// coefficient extremes and ignored register indexes. Random phases follow,
// each with a fresh rotation setting and its own request gap pattern.
// ----------------------------------------------------------------------------
module tb_axis_angle_path_rotator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import aapr_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int PIPE_LATENCY    = 6;
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int MAX_REPORTS     = 10;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 150;
   // Q1.16 value of one over the square root of three, for a diagonal axis.
   localparam int DIAG_Q16        = 37837;

   // Cosine and sine of the eight multiples of 45 degrees, in Q1.16.
   localparam int COS_STEPS [8] = '{65536, 46341, 0, -46341, -65536, -46341, 0, 46341};
   localparam int SIN_STEPS [8] = '{0, 46341, 65536, 46341, 0, -46341, -65536, -46341};

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   req_type              req_data         = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [COEF_W-1:0]    csr_write_data   = '0;

   // The testbench's own copy of the rotation registers, updated on every write.
   cfg_type     rotation_regs;
   rsp_type     pending_rotations [$];
   int unsigned max_gap          = 0;
   int unsigned cycle_count      = 0;
   int unsigned mismatch_count   = 0;
   int unsigned results_checked  = 0;
   int unsigned elements_sent    = 0;
   int unsigned register_writes  = 0;
   int unsigned settings_used    = 0;
   string       vec_field_names [6] = '{"rot_point_x", "rot_point_y", "rot_point_z",
                                        "rot_tangent_x", "rot_tangent_y", "rot_tangent_z"};

   axis_angle_path_rotator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Saturates a full-precision result to the signed 32-bit range.
   function automatic logic [VEC_W-1:0] clamp_q16(input longint value);
      if (value > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end
      if (value < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return value[VEC_W-1:0];
   endfunction

   // Rodrigues' rotation of one vector. Every intermediate is held exactly in
   // 64 bits, and every >>> is a floor shift because all operands are signed.
   function automatic void rotate_vector(input cfg_type regs,
                                         input longint vx, input longint vy,
                                         input longint vz,
                                         output logic [VEC_W-1:0] ox,
                                         output logic [VEC_W-1:0] oy,
                                         output logic [VEC_W-1:0] oz);
      longint kx, ky, kz, c, s;
      longint cross_x, cross_y, cross_z, dot, w;
      kx = $signed(regs.axis_x);
      ky = $signed(regs.axis_y);
      kz = $signed(regs.axis_z);
      c  = $signed(regs.cos_angle);
      s  = $signed(regs.sin_angle);
      cross_x = (ky * vz - kz * vy) >>> FRAC;
      cross_y = (kz * vx - kx * vz) >>> FRAC;
      cross_z = (kx * vy - ky * vx) >>> FRAC;
      dot     = (kx * vx + ky * vy + kz * vz) >>> FRAC;
      w       = (dot * (longint'(ONE_Q16) - c)) >>> FRAC;
      ox = clamp_q16((c * vx + s * cross_x + w * kx) >>> FRAC);
      oy = clamp_q16((c * vy + s * cross_y + w * ky) >>> FRAC);
      oz = clamp_q16((c * vz + s * cross_z + w * kz) >>> FRAC);
   endfunction

   function automatic rsp_type predict_rotation(input req_type element, input cfg_type regs);
      rsp_type            result;
      logic [VEC_W-1:0]   rx, ry, rz;
      rotate_vector(regs, longint'($signed(element.point_x)),
                    longint'($signed(element.point_y)),
                    longint'($signed(element.point_z)), rx, ry, rz);
      result.rot_point_x = rx;
      result.rot_point_y = ry;
      result.rot_point_z = rz;
      rotate_vector(regs, longint'($signed(element.tangent_x)),
                    longint'($signed(element.tangent_y)),
                    longint'($signed(element.tangent_z)), rx, ry, rz);
      result.rot_tangent_x = rx;
      result.rot_tangent_y = ry;
      result.rot_tangent_z = rz;
      result.last_element  = element.end_of_path;
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking. Results are sampled at the edge that ends their strobe
   // cycle, so the values seen here are the ones the block presented during
   // that cycle. A strobe with nothing queued counts as a mismatch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rotation
      rsp_type          expected;
      logic [VEC_W-1:0] want [6];
      logic [VEC_W-1:0] got  [6];
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rotations.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("[%0t] result strobe with no transaction outstanding: %h",
                        $realtime, rsp_data);
            end
         end else begin
            expected = pending_rotations.pop_front();
            results_checked++;
            want = '{expected.rot_point_x, expected.rot_point_y, expected.rot_point_z,
                     expected.rot_tangent_x, expected.rot_tangent_y,
                     expected.rot_tangent_z};
            got  = '{rsp_data.rot_point_x, rsp_data.rot_point_y, rsp_data.rot_point_z,
                     rsp_data.rot_tangent_x, rsp_data.rot_tangent_y,
                     rsp_data.rot_tangent_z};
            for (int f = 0; f < 6; f++) begin
               if (got[f] !== want[f]) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("[%0t] result %0d %s: expected %h, got %h",
                              $realtime, results_checked, vec_field_names[f],
                              want[f], got[f]);
                  end
               end
            end
            if (rsp_data.last_element !== expected.last_element) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("[%0t] result %0d last_element: expected %b, got %b",
                           $realtime, results_checked, expected.last_element,
                           rsp_data.last_element);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Presents one path element and holds it until the block takes it. With a
   // zero gap start stays high, so the next call continues the burst without
   // ever lowering start in the same time step.
   task automatic send_element(input req_type element);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      start    <= 1'b1;
      req_data <= element;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rotations = {pending_rotations, predict_rotation(element, rotation_regs)};
      elements_sent++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One register write. The enable is left high so that writes can follow
   // back to back; whoever issues the last write lowers it.
   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [COEF_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= value;
      @(posedge clock);
      case (reg_index)
         REG_AXIS_X: rotation_regs.axis_x    = value;
         REG_AXIS_Y: rotation_regs.axis_y    = value;
         REG_AXIS_Z: rotation_regs.axis_z    = value;
         REG_COS:    rotation_regs.cos_angle = value;
         REG_SIN:    rotation_regs.sin_angle = value;
         default: ;  // indexes past the sine register have no effect
      endcase
      register_writes++;
   endtask

   // Loads a full rotation, optionally followed by writes to the unused
   // indexes, which the block must ignore.
   task automatic program_rotation(input logic [COEF_W-1:0] ax, input logic [COEF_W-1:0] ay,
                                   input logic [COEF_W-1:0] az, input logic [COEF_W-1:0] c,
                                   input logic [COEF_W-1:0] s, input int unsigned junk_writes);
      write_register(REG_AXIS_X, ax);
      write_register(REG_AXIS_Y, ay);
      write_register(REG_AXIS_Z, az);
      write_register(REG_COS, c);
      write_register(REG_SIN, s);
      for (int j = 0; j < junk_writes; j++) begin
         write_register(CSR_IDX_W'(REG_SIN + 1 + (j % 3)), random_coef());
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Stops issuing requests and lets every outstanding transaction come back
   // before the registers are touched again.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic req_type make_element(input logic [VEC_W-1:0] px,
                                            input logic [VEC_W-1:0] py,
                                            input logic [VEC_W-1:0] pz,
                                            input logic [VEC_W-1:0] tx,
                                            input logic [VEC_W-1:0] ty,
                                            input logic [VEC_W-1:0] tz,
                                            input logic eop);
      req_type element;
      element.point_x     = px;
      element.point_y     = py;
      element.point_z     = pz;
      element.tangent_x   = tx;
      element.tangent_y   = ty;
      element.tangent_z   = tz;
      element.end_of_path = eop;
      return element;
   endfunction

   // Half full-range values, the rest modest coordinates that rarely saturate
   // and a sprinkle of extremes.
   function automatic logic [VEC_W-1:0] random_component();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return $urandom();
      end
      if (pick < 8) begin
         return VEC_W'(int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      end
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // Register values: extremes of the 18-bit field, plus and minus one, zero,
   // values within one, and any pattern at all.
   function automatic logic [COEF_W-1:0] random_coef();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 18'h1FFFF;
         1:       return 18'h20000;
         2:       return 18'h10000;
         3:       return 18'h30000;
         4:       return 18'h00000;
         5, 6, 7: return COEF_W'(int'($urandom_range(0, 131072)) - 65536);
         default: return COEF_W'($urandom());
      endcase
   endfunction

   function automatic req_type random_element();
      return make_element(random_component(), random_component(), random_component(),
                          random_component(), random_component(), random_component(),
                          $urandom_range(0, 7) == 0);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // The reset registers describe the identity rotation, so every element
   // must come back unchanged, extremes included.
   task automatic test_identity_passthrough();
      max_gap = 2;
      send_element(make_element('0, '0, '0, '0, '0, '0, 1'b0));
      send_element(make_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_element(make_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
      send_element(make_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b1));
   endtask

   // Exact turns about each coordinate axis, and a 45-degree turn about the diagonal.
   task automatic test_quarter_turns();
      max_gap = 0;
      drain_pipeline();
      program_rotation(18'h00000, 18'h00000, 18'h10000, 18'h00000, 18'h10000, 0);
      send_element(make_element(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000, 1'b0));
      send_element(random_element());
      drain_pipeline();
      program_rotation(18'h10000, 18'h00000, 18'h00000, 18'h00000, 18'h30000, 0);
      send_element(make_element(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                32'h0004_0000, 32'hFFFB_0000, 32'h0006_0000, 1'b1));
      drain_pipeline();
      program_rotation(18'h00000, 18'h30000, 18'h00000, 18'h30000, 18'h00000, 0);
      send_element(random_element());
      drain_pipeline();
      program_rotation(COEF_W'(DIAG_Q16), COEF_W'(DIAG_Q16), COEF_W'(DIAG_Q16),
                       COEF_W'(46341), COEF_W'(46341), 0);
      send_element(make_element(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0001,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0));
   endtask

   // Registers at both ends of their 18-bit range, and an axis that is not
   // unit length with cosine and sine that do not agree. Large inputs here
   // drive the outputs into saturation on both sides.
   task automatic test_coefficient_extremes();
      max_gap = 1;
      drain_pipeline();
      program_rotation(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);
      send_element(make_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_element(make_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
      send_element(make_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
      drain_pipeline();
      program_rotation(18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 0);
      send_element(make_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      send_element(make_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send_element(make_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
      drain_pipeline();
      program_rotation(18'h10000, 18'h10000, 18'h10000, 18'h08000, 18'h10000, 0);
      send_element(make_element(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 1'b0));
      send_element(random_element());
   endtask

   // Writes to the three indexes past the sine register must leave the
   // rotation as it was.
   task automatic test_ignored_indexes();
      max_gap = 3;
      drain_pipeline();
      program_rotation(18'h00000, 18'h00000, 18'h10000, 18'h00000, 18'h10000, 3);
      repeat (3) send_element(random_element());
   endtask

   // Random phases: half rotate in 45-degree steps about a coordinate or
   // diagonal axis, the rest arbitrary register writes of any index. Some phases
   // stream back to back, the others insert random gaps between requests.
   task automatic test_random_paths();
      int ax, ay, az, sign, turn;
      for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         drain_pipeline();
         if ($urandom_range(0, 1) == 1) begin
            sign = ($urandom_range(0, 1) == 1) ? 65536 : -65536;
            ax = 0;
            ay = 0;
            az = 0;
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 2))
                  0:       ax = sign;
                  1:       ay = sign;
                  default: az = sign;
               endcase
            end else begin
               ax = ($urandom_range(0, 1) == 1) ? DIAG_Q16 : -DIAG_Q16;
               ay = ($urandom_range(0, 1) == 1) ? DIAG_Q16 : -DIAG_Q16;
               az = ($urandom_range(0, 1) == 1) ? DIAG_Q16 : -DIAG_Q16;
            end
            turn = $urandom_range(0, 7);
            program_rotation(COEF_W'(ax), COEF_W'(ay), COEF_W'(az),
                             COEF_W'(COS_STEPS[turn]), COEF_W'(SIN_STEPS[turn]),
                             $urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               write_register(CSR_IDX_W'($urandom_range(0, 7)), random_coef());
            end
            csr_write_enable <= 1'b0;
            settings_used++;
         end
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         repeat (ITEMS_PER_PHASE) send_element(random_element());
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run_tests
      // The block resets to the identity rotation about z.
      rotation_regs.axis_x    = '0;
      rotation_regs.axis_y    = '0;
      rotation_regs.axis_z    = COEF_W'(ONE_Q16);
      rotation_regs.cos_angle = COEF_W'(ONE_Q16);
      rotation_regs.sin_angle = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_identity_passthrough();
      test_quarter_turns();
      test_coefficient_extremes();
      test_ignored_indexes();
      test_random_paths();

      // Wait out every outstanding transaction, then a few more pipeline
      // depths so that any stray strobe is caught.
      drain_pipeline();
      repeat (4 * PIPE_LATENCY) @(posedge clock);

      $display("Sent %0d path elements under %0d rotation settings (%0d register writes);",
               elements_sent, settings_used, register_writes);
      $display("checked %0d results, %0d mismatches, %0d still outstanding.",
               results_checked, mismatch_count, pending_rotations.size());
      if (mismatch_count == 0 && pending_rotations.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_rotations.size());
      $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
design/aapr_pkg.sv
design/aapr_lane.sv
design/aapr_merge.sv
design/axis_angle_path_rotator_unit.sv
design/aapr_checker.sv
verif/tb_axis_angle_path_rotator_unit.sv
